[design/pcm_nearest_resampler_unit_defines.svh]
// Assertion macros for the resampler
`ifndef PCM_NEAREST_RESAMPLER_UNIT_DEFINES_SVH
`define PCM_NEAREST_RESAMPLER_UNIT_DEFINES_SVH

// same-cycle implication
`define PNR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PNR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/pnr_pkg.sv]
`default_nettype none

package pnr_pkg;

  localparam int COUNT_BITS  = 24;
  localparam int STEP_W      = 10;
  localparam int WIDTH_W     = 2;
  localparam int OCOUNT_W    = 24;
  localparam int SAMPLE_W    = 16;
  localparam int FRAC_W      = 8;
  localparam int SKIP_W      = 3;
  localparam int CMP_W       = (COUNT_BITS > OCOUNT_W) ? COUNT_BITS : OCOUNT_W;
  localparam int ADD_W       = COUNT_BITS + 1;
  localparam int APB_AW      = 4;
  localparam int APB_DW      = 32;
  localparam int MAX_RESULTS = 16;
  localparam int RES_W       = $clog2(MAX_RESULTS) + 1;

  localparam logic [STEP_W-1:0]  STEP_MIN = STEP_W'(16);
  localparam logic [STEP_W-1:0]  STEP_RST = STEP_W'(256);
  localparam logic [WIDTH_W-1:0] WIDTH_8  = WIDTH_W'(1);
  localparam logic [WIDTH_W-1:0] WIDTH_16 = WIDTH_W'(2);

  typedef enum logic [1:0] {
    REG_STEP         = 2'd0,
    REG_IN_WIDTH     = 2'd1,
    REG_OUT_WIDTH    = 2'd2,
    REG_OUTPUT_COUNT = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [STEP_W-1:0]   step_q8;
    logic [WIDTH_W-1:0]  in_width;
    logic [WIDTH_W-1:0]  out_width;
    logic [OCOUNT_W-1:0] output_count;
  } cfg_t;

  function automatic logic [SAMPLE_W-1:0] conv_sample(
    input logic [SAMPLE_W-1:0] raw,
    input logic [WIDTH_W-1:0]  iw,
    input logic [WIDTH_W-1:0]  ow
  );
    logic [SAMPLE_W-1:0] s16;
    if (iw == WIDTH_16) begin
      s16 = raw;
    end else begin
      s16 = {~raw[7], raw[6:0], 8'h00};
    end
    if (ow == WIDTH_16) begin
      return s16;
    end
    return {{8{s16[15]}}, s16[15:8]};
  endfunction

endpackage

`default_nettype wire

[design/pnr_regs.sv]
`default_nettype none

module pnr_regs
  import pnr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_STEP:         cfg_nxt.step_q8      = pwdata[STEP_W-1:0];
        REG_IN_WIDTH:     cfg_nxt.in_width     = pwdata[WIDTH_W-1:0];
        REG_OUT_WIDTH:    cfg_nxt.out_width    = pwdata[WIDTH_W-1:0];
        REG_OUTPUT_COUNT: cfg_nxt.output_count = pwdata[OCOUNT_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_STEP:         prdata = APB_DW'(cfg_r.step_q8);
      REG_IN_WIDTH:     prdata = APB_DW'(cfg_r.in_width);
      REG_OUT_WIDTH:    prdata = APB_DW'(cfg_r.out_width);
      REG_OUTPUT_COUNT: prdata = APB_DW'(cfg_r.output_count);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_q8      <= STEP_RST;
      cfg_r.in_width     <= WIDTH_8;
      cfg_r.out_width    <= WIDTH_8;
      cfg_r.output_count <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

[design/pcm_nearest_resampler_unit.sv]
// Nearest-neighbour PCM resampler, one shared adder under a three-state sequencer.
// First output word valid once the sequencer has passed S_CNT into S_HOLD after the
// input word is taken. Dropped or ignored inputs keep it in S_IDLE; each output takes
// one count step and one accumulator step on the adder; input stalls outside S_IDLE.
// Reset (rst_n low, synchronous): step 256, 8-bit in and out, output count 0,
// accumulator, skip count and emitted count cleared, no word pending.
`default_nettype none
`include "pcm_nearest_resampler_unit_defines.svh"

module pcm_nearest_resampler_unit
  import pnr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [SAMPLE_W-1:0] in_raw_sample,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic                     out_last_out,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [APB_AW-1:0]   paddr,
  input  wire logic [APB_DW-1:0]   pwdata,
  output logic      [APB_DW-1:0]   prdata,
  output logic                     pready
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CNT  = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  cfg_t cfg;

  state_t                state_r, state_nxt;
  logic [FRAC_W-1:0]     frac_r, frac_nxt;
  logic [SKIP_W-1:0]     skip_left_r, skip_left_nxt;
  logic [COUNT_BITS-1:0] emitted_r, emitted_nxt;
  logic [SAMPLE_W-1:0]   val_r, val_nxt;
  logic                  last_r, last_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [RES_W-1:0]      nemit_r, nemit_nxt;

  logic [STEP_W-1:0]     step_eff;
  logic [ADD_W-1:0]      add_a, add_b, add_sum;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [SKIP_W-1:0]     carry;
  logic                  limit_hit, inc_hit, in_acc, out_acc;

  pnr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign step_eff = (cfg.step_q8 < STEP_MIN) ? STEP_MIN : cfg.step_q8;

  always_comb begin
    if (state_r == S_HOLD) begin
      add_a = ADD_W'(frac_r);
      add_b = ADD_W'(step_eff);
    end else begin
      add_a = ADD_W'(emitted_r);
      add_b = ADD_W'(1);
    end
  end

  assign add_sum   = add_a + add_b;
  assign carry     = add_sum[FRAC_W+SKIP_W-1:FRAC_W];
  assign cnt_inc   = (&emitted_r) ? emitted_r : add_sum[COUNT_BITS-1:0];
  assign limit_hit = CMP_W'(emitted_r) >= CMP_W'(cfg.output_count);
  assign inc_hit   = CMP_W'(cnt_inc) >= CMP_W'(cfg.output_count);

  assign in_stall     = (state_r != S_IDLE);
  assign in_acc       = in_valid && !in_stall;
  assign out_valid    = out_valid_r;
  assign out_acc      = out_valid_r && !out_stall;
  assign out_sample   = signed'(val_r);
  assign out_last_out = last_r;

  always_comb begin
    state_nxt     = state_r;
    frac_nxt      = frac_r;
    skip_left_nxt = skip_left_r;
    emitted_nxt   = emitted_r;
    val_nxt       = val_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    nemit_nxt     = nemit_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && !limit_hit) begin
          if (skip_left_r != '0) begin
            skip_left_nxt = skip_left_r - SKIP_W'(1);
          end else begin
            val_nxt   = conv_sample(in_raw_sample, cfg.in_width, cfg.out_width);
            nemit_nxt = '0;
            state_nxt = S_CNT;
          end
        end
      end
      S_CNT: begin
        emitted_nxt   = cnt_inc;
        last_nxt      = inc_hit;
        out_valid_nxt = 1'b1;
        nemit_nxt     = nemit_r + RES_W'(1);
        state_nxt     = S_HOLD;
      end
      S_HOLD: begin
        if (out_acc) begin
          out_valid_nxt = 1'b0;
          frac_nxt      = add_sum[FRAC_W-1:0];
          if (carry != '0) begin
            skip_left_nxt = carry - SKIP_W'(1);
            state_nxt     = S_IDLE;
          end else if (!limit_hit && (nemit_r < RES_W'(MAX_RESULTS))) begin
            state_nxt = S_CNT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      frac_r      <= '0;
      skip_left_r <= '0;
      emitted_r   <= '0;
      out_valid_r <= 1'b0;
      nemit_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      frac_r      <= frac_nxt;
      skip_left_r <= skip_left_nxt;
      emitted_r   <= emitted_nxt;
      out_valid_r <= out_valid_nxt;
      nemit_r     <= nemit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    last_r <= last_nxt;
  end

  `PNR_ASSERT_IMP(a_busy_stall, clk, rst_n, out_valid_r, in_stall, "input taken while a word is pending")
  `PNR_ASSERT_NXT(a_last_ends, clk, rst_n, out_acc && last_r, !out_valid_r, "word emitted past the output count")
  `PNR_ASSERT_NXT(a_skip_drops, clk, rst_n, in_acc && !limit_hit && (skip_left_r != '0), !out_valid_r && (skip_left_r == $past(skip_left_r) - SKIP_W'(1)), "skipped input not dropped")
  `PNR_ASSERT_IMP(a_skip_range, clk, rst_n, 1'b1, !skip_left_r[SKIP_W-1], "skip count out of range")

endmodule

`default_nettype wire

[dv/pnr_checker.sv]
module pnr_checker
  import pnr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [SAMPLE_W-1:0] in_raw_sample,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [SAMPLE_W-1:0] out_sample,
  input  logic                out_last_out,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output int                  errors,
  output int                  pending,
  output int                  live_words,
  output int                  words_out
);

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } pcm_word_t;

  pcm_word_t due_words[$];
  pcm_word_t want;

  logic [STEP_W-1:0]     step_q8;
  logic [WIDTH_W-1:0]    in_width;
  logic [WIDTH_W-1:0]    out_width;
  logic [OCOUNT_W-1:0]   count_limit;
  logic [FRAC_W-1:0]     frac_acc;
  logic [SKIP_W-1:0]     skip_left;
  logic [COUNT_BITS-1:0] emitted;

  task automatic resample_word(input logic [SAMPLE_W-1:0] raw);
    logic [SAMPLE_W-1:0] wide;
    logic [SAMPLE_W-1:0] picked;
    logic [STEP_W:0]     stride;
    logic [STEP_W:0]     acc_sum;
    int                  n;
    stride = (step_q8 < STEP_MIN) ? {1'b0, STEP_MIN} : {1'b0, step_q8};
    if (emitted >= count_limit) return;
    live_words++;
    if (skip_left != '0) begin
      skip_left = skip_left - 1'b1;
      return;
    end
    wide = (in_width == WIDTH_16) ? raw : {raw[7:0] ^ 8'h80, 8'h00};
    picked = (out_width == WIDTH_16) ? wide : {{8{wide[15]}}, wide[15:8]};
    n = 0;
    while (n < MAX_RESULTS && emitted < count_limit) begin
      if (emitted != '1) emitted = emitted + 1'b1;
      due_words.push_back('{sample: picked, last: (emitted >= count_limit)});
      n++;
      acc_sum = frac_acc + stride;
      frac_acc = acc_sum[FRAC_W-1:0];
      if (acc_sum[STEP_W:FRAC_W] != '0) begin
        skip_left = SKIP_W'(acc_sum[STEP_W:FRAC_W] - 1'b1);
        break;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      step_q8 = STEP_RST;
      in_width = WIDTH_8;
      out_width = WIDTH_8;
      count_limit = '0;
      frac_acc = '0;
      skip_left = '0;
      emitted = '0;
      due_words.delete();
      errors = 0;
      live_words = 0;
      words_out = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[APB_AW-1:2]))
          REG_STEP:         step_q8 = pwdata[STEP_W-1:0];
          REG_IN_WIDTH:     in_width = pwdata[WIDTH_W-1:0];
          REG_OUT_WIDTH:    out_width = pwdata[WIDTH_W-1:0];
          REG_OUTPUT_COUNT: count_limit = pwdata[OCOUNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) resample_word(in_raw_sample);
      if (out_valid && !out_stall) begin
        words_out++;
        if (due_words.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected output word: sample %0d last %0b",
                     $signed(out_sample), out_last_out);
        end else begin
          want = due_words.pop_front();
          if (want.sample !== out_sample || want.last !== out_last_out) begin
            errors++;
            if (errors <= 10)
              $display("output word %0d wrong: sample exp %0d got %0d, last exp %0b got %0b",
                       words_out, $signed(want.sample), $signed(out_sample),
                       want.last, out_last_out);
          end
        end
      end
    end
    pending = due_words.size();
  end

endmodule

[dv/tb.sv]
module tb;
  import pnr_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int ITEM_TARGET = 430;
  localparam int DRAIN_CYCLES = 24;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [SAMPLE_W-1:0]        in_raw_sample;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_last_out;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [APB_AW-1:0]          paddr;
  logic [APB_DW-1:0]          pwdata;
  logic [APB_DW-1:0]          prdata;
  logic                       pready;

  int errors;
  int pending;
  int live_words;
  int words_out;
  int words_sent = 0;
  int settings = 0;
  int cycles = 0;
  bit calm = 1'b0;

  pcm_nearest_resampler_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_raw_sample(in_raw_sample),
    .out_valid(out_valid), .out_stall(out_stall), .out_sample(out_sample),
    .out_last_out(out_last_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  pnr_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_raw_sample(in_raw_sample),
    .out_valid(out_valid), .out_stall(out_stall), .out_sample(out_sample),
    .out_last_out(out_last_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .errors(errors), .pending(pending), .live_words(live_words),
    .words_out(words_out)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      hold = calm ? 0 : $urandom_range(0, 3);
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  task automatic push_sample(input logic [SAMPLE_W-1:0] raw);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_raw_sample = raw;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // drop valid, wait for every due word, then let the datapath settle
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic program_regs(input logic [STEP_W-1:0] step,
                              input logic [WIDTH_W-1:0] iw,
                              input logic [WIDTH_W-1:0] ow,
                              input logic [OCOUNT_W-1:0] count,
                              input bit relative);
    logic [OCOUNT_W-1:0] limit;
    drain();
    limit = relative ? OCOUNT_W'(words_out) + count : count;
    write_reg(REG_STEP, APB_DW'(step));
    write_reg(REG_IN_WIDTH, APB_DW'(iw));
    write_reg(REG_OUT_WIDTH, APB_DW'(ow));
    write_reg(REG_OUTPUT_COUNT, APB_DW'(limit));
    settings++;
  endtask

  initial begin
    logic [STEP_W-1:0] step;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_raw_sample = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // output count is zero out of reset: ignored
    push_sample(16'h1234);
    push_sample(16'hFFFF);

    program_regs(10'd256, WIDTH_8, WIDTH_8, 24'hFFFFFF, 1'b0);
    push_sample(16'h0000);
    push_sample(16'h00FF);
    push_sample(16'h0080);
    push_sample(16'h007F);
    push_sample(16'hFF00);

    program_regs(10'd256, WIDTH_16, WIDTH_16, 24'hFFFFFF, 1'b0);
    push_sample(16'h8000);
    push_sample(16'h7FFF);
    push_sample(16'hFFFF);
    push_sample(16'h0001);

    program_regs(10'd128, WIDTH_16, WIDTH_8, 24'hFFFFFF, 1'b0);
    push_sample(16'h8000);
    push_sample(16'h7F80);
    push_sample(16'h00FF);

    // step below the floor saturates
    program_regs(10'd0, 2'd0, WIDTH_16, 24'hFFFFFF, 1'b0);
    push_sample(16'h00FF);
    push_sample(16'h0000);

    program_regs(10'd1023, 2'd3, WIDTH_16, 24'hFFFFFF, 1'b0);
    repeat (6) push_sample(SAMPLE_W'($urandom_range(0, 65535)));

    // count lowered below what has been emitted
    program_regs(10'd256, WIDTH_16, WIDTH_16, 24'd0, 1'b0);
    push_sample(16'h4321);

    // limit reached part way through a repeated word
    program_regs(10'd16, WIDTH_16, WIDTH_16, 24'd5, 1'b1);
    push_sample(16'hA5A5);
    push_sample(16'h5A5A);

    program_regs(10'd64, WIDTH_8, 2'd3, 24'd3, 1'b1);
    push_sample(16'h0011);
    push_sample(16'h00EE);

    while (words_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 5))
        0:       step = STEP_W'($urandom_range(0, 15));
        1:       step = 10'd1023;
        2:       step = STEP_W'($urandom_range(16, 255));
        3:       step = STEP_W'($urandom_range(256, 1023));
        default: step = STEP_W'($urandom_range(0, 1023));
      endcase
      case ($urandom_range(0, 3))
        0: program_regs(step, WIDTH_W'($urandom_range(0, 3)), WIDTH_W'($urandom_range(0, 3)),
                        OCOUNT_W'($urandom_range(1, 40)), 1'b1);
        1: program_regs(step, WIDTH_W'($urandom_range(0, 3)), WIDTH_W'($urandom_range(0, 3)),
                        24'hFFFFFF, 1'b0);
        default: program_regs(step, WIDTH_W'($urandom_range(0, 3)),
                              WIDTH_W'($urandom_range(0, 3)),
                              OCOUNT_W'($urandom_range(40, 600)), 1'b1);
      endcase
      calm = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(15, 30)) push_sample(SAMPLE_W'($urandom_range(0, 65535)));
    end
    calm = 1'b0;

    drain();
    $display("Sent %0d input words (%0d not ignored), checked %0d output words.",
             words_sent, live_words, words_out);
    $display("Visited %0d register settings incl. saturated and maximum steps and all width codes.",
             settings);
    if (errors == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[pcm_nearest_resampler_unit.f]
+incdir+design
design/pnr_pkg.sv
design/pnr_regs.sv
design/pcm_nearest_resampler_unit.sv
dv/pnr_checker.sv
dv/tb.sv
